// ===== hdl/bth_pkg.sv =====
package bth_pkg;

    localparam int HEAP_BYTES = 262144;
    localparam int HEAP8      = HEAP_BYTES / 8;
    localparam int MIN8       = 2;
    localparam int OFF_W      = $clog2(HEAP8) + 1;
    localparam int TAG_WORDS  = HEAP8 * 2;
    localparam int TAG_AW     = $clog2(TAG_WORDS);
    localparam int TAG_W      = OFF_W + 1;
    localparam int NEED_W     = 30;
    localparam logic [31:0] HEAP_BASE_RST = 32'h0020_0000;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_INIT  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FAIL    = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic REG_HEAP_BASE = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_TAKE,
        OP_ADVANCE,
        OP_ADD_NEXT,
        OP_ADD_PREV
    } t_op;

    typedef enum logic {
        RS_CUR,
        RS_NEXT
    } t_rsel;

    typedef enum logic [2:0] {
        WS_NONE,
        WS_NEED_HDR,
        WS_NEED_FTR,
        WS_REST_HDR,
        WS_REST_FTR,
        WS_CUR_HDR,
        WS_CUR_FTR
    } t_wsel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ALLOC_OK,
        RES_FAIL,
        RES_IGNORE,
        RES_DONE
    } t_res;

    typedef struct packed {
        t_op   op;
        t_rsel rsel;
        t_wsel wsel;
        logic  wr_alloc;
        t_res  res;
    } t_cmd;

    typedef struct packed {
        logic req_bad;
        logic data_null;
        logic off_end;
        logic rd_ok;
        logic rd_free;
        logic fit;
        logic split;
        logic hit;
        logic past;
        logic next_end;
        logic prev_free;
        logic out_busy;
    } t_stat;

    function automatic logic [TAG_AW-1:0] hdr_word(input logic [OFF_W-1:0] off);
        return {off[OFF_W-2:0], 1'b0};
    endfunction

    function automatic logic [TAG_AW-1:0] ftr_word(input logic [OFF_W-1:0] last);
        return {last[OFF_W-2:0], 1'b0} - TAG_AW'(1);
    endfunction

endpackage

// ===== hdl/bth_in_if.sv =====
interface bth_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] request_size;
    logic [31:0] data_address;

    modport source (output valid, mode, request_size, data_address, input ready);
    modport sink (input valid, mode, request_size, data_address, output ready);
endinterface

// ===== hdl/bth_out_if.sv =====
interface bth_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic [1:0]  status;

    modport source (output valid, result_address, status, input ready);
    modport sink (input valid, result_address, status, output ready);
endinterface

// ===== hdl/boundary_tag_heap_allocator.sv =====
// channel   dir  handshake     payload
// i_req     in   valid/ready   mode, request_size, data_address
// o_rsp     out  valid/ready   result_address, status
// apb       in   psel/penable  paddr, pwdata, prdata (heap_base at 0)
//
// Allocate and free visit each block on the walk with one read of the tag RAM and
// one decision, plus the checks and tag writes of allocate and of free. Reinitialize
// rewrites the heap header and footer. After reset the heap header is written before
// the first request is taken. A waiting result does not block the next request; a
// finished request holds until the output register frees.
module boundary_tag_heap_allocator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bth_in_if.sink          i_req,
    bth_out_if.source       o_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [31:0]    r_heap_base;
    bth_pkg::t_cmd  cmd;
    bth_pkg::t_stat stat;
    logic           ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= bth_pkg::HEAP_BASE_RST;
        end else if (psel && penable && pwrite && (paddr[2] == bth_pkg::REG_HEAP_BASE)) begin
            r_heap_base <= pwdata;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == bth_pkg::REG_HEAP_BASE) ? r_heap_base : '0;
    assign i_req.ready = ready;

    bth_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_mode  (i_req.mode),
        .i_stat  (stat),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    bth_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_request_size   (i_req.request_size),
        .i_data_address   (i_req.data_address),
        .i_heap_base      (r_heap_base),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_result_address (o_rsp.result_address),
        .o_status         (o_rsp.status)
    );

endmodule

// ===== hdl/bth_ram.sv =====
module bth_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bth_dp.sv =====
module bth_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bth_pkg::t_cmd       i_cmd,
    output bth_pkg::t_stat      o_stat,
    input  logic [31:0]         i_request_size,
    input  logic [31:0]         i_data_address,
    input  logic [31:0]         i_heap_base,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [31:0]         o_result_address,
    output logic [1:0]          o_status
);

    logic [bth_pkg::OFF_W-1:0]  r_off;
    logic [bth_pkg::OFF_W-1:0]  r_sz;
    logic [bth_pkg::OFF_W-1:0]  r_need;
    logic [bth_pkg::OFF_W-1:0]  r_rest;
    logic [bth_pkg::OFF_W-1:0]  r_prev;
    logic                       r_prev_alloc;
    logic                       r_have_prev;
    logic                       r_req_zero;
    logic                       r_need_big;
    logic                       r_data_null;
    logic [31:0]                r_target;
    logic                       r_out_valid;
    logic [31:0]                r_result_address;
    logic [1:0]                 r_status;

    logic [bth_pkg::NEED_W-1:0] n_need;
    logic [bth_pkg::TAG_W-1:0]  rdata;
    logic [bth_pkg::OFF_W-1:0]  rd_sz;
    logic                       rd_alloc;
    logic [bth_pkg::OFF_W-1:0]  next_off;
    logic [bth_pkg::OFF_W-1:0]  need_off;
    logic [bth_pkg::OFF_W-1:0]  rd_base;
    logic [bth_pkg::OFF_W-1:0]  room;
    logic                       rd_ok;
    logic [31:0]                off_bytes;
    logic                       we;
    logic [bth_pkg::TAG_AW-1:0] waddr;
    logic [bth_pkg::TAG_W-1:0]  wdata;

    assign rd_sz     = rdata[bth_pkg::TAG_W-1:1];
    assign rd_alloc  = rdata[0];
    assign next_off  = r_off + r_sz;
    assign need_off  = r_off + r_need;
    assign rd_base   = (i_cmd.rsel == bth_pkg::RS_NEXT) ? next_off : r_off;
    assign room      = bth_pkg::OFF_W'(bth_pkg::HEAP8) - rd_base;
    assign rd_ok     = (rd_sz != '0) && (rd_sz <= room);
    assign off_bytes = 32'({r_off, 3'b000});
    assign n_need    = bth_pkg::NEED_W'((33'(i_request_size) + 33'd7) >> 3)
                       + bth_pkg::NEED_W'(1);

    always_comb begin
        o_stat           = '0;
        o_stat.req_bad   = r_req_zero || r_need_big;
        o_stat.data_null = r_data_null;
        o_stat.off_end   = r_off >= bth_pkg::OFF_W'(bth_pkg::HEAP8);
        o_stat.rd_ok     = rd_ok;
        o_stat.rd_free   = !rd_alloc;
        o_stat.fit       = rd_ok && !rd_alloc && (rd_sz >= r_need);
        o_stat.split     = {1'b0, rd_sz} >= ({1'b0, r_need} + (bth_pkg::OFF_W + 1)'(bth_pkg::MIN8));
        o_stat.hit       = r_target == off_bytes;
        o_stat.past      = off_bytes > r_target;
        o_stat.next_end  = next_off >= bth_pkg::OFF_W'(bth_pkg::HEAP8);
        o_stat.prev_free = r_have_prev && !r_prev_alloc;
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    always_comb begin
        we    = 1'b1;
        waddr = bth_pkg::hdr_word(r_off);
        wdata = {r_sz, i_cmd.wr_alloc};
        case (i_cmd.wsel)
            bth_pkg::WS_NEED_HDR: begin
                waddr = bth_pkg::hdr_word(r_off);
                wdata = {r_need, 1'b1};
            end
            bth_pkg::WS_NEED_FTR: begin
                waddr = bth_pkg::ftr_word(need_off);
                wdata = {r_need, 1'b1};
            end
            bth_pkg::WS_REST_HDR: begin
                waddr = bth_pkg::hdr_word(need_off);
                wdata = {r_rest, 1'b0};
            end
            bth_pkg::WS_REST_FTR: begin
                waddr = bth_pkg::ftr_word(next_off);
                wdata = {r_rest, 1'b0};
            end
            bth_pkg::WS_CUR_HDR: begin
                waddr = bth_pkg::hdr_word(r_off);
                wdata = {r_sz, i_cmd.wr_alloc};
            end
            bth_pkg::WS_CUR_FTR: begin
                waddr = bth_pkg::ftr_word(next_off);
                wdata = {r_sz, i_cmd.wr_alloc};
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    bth_ram #(
        .W     (bth_pkg::TAG_W),
        .DEPTH (bth_pkg::TAG_WORDS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (bth_pkg::hdr_word(rd_base)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bth_pkg::OP_LOAD: begin
                r_off       <= '0;
                r_have_prev <= 1'b0;
                r_req_zero  <= i_request_size == '0;
                r_need_big  <= n_need > bth_pkg::NEED_W'(bth_pkg::HEAP8);
                r_need      <= n_need[bth_pkg::OFF_W-1:0];
                r_data_null <= i_data_address == '0;
                r_target    <= i_data_address - i_heap_base - 32'd4;
            end
            bth_pkg::OP_INIT: begin
                r_off <= '0;
                r_sz  <= bth_pkg::OFF_W'(bth_pkg::HEAP8);
            end
            bth_pkg::OP_TAKE: begin
                r_sz   <= rd_sz;
                r_rest <= rd_sz - r_need;
            end
            bth_pkg::OP_ADVANCE: begin
                r_prev       <= r_off;
                r_prev_alloc <= rd_alloc;
                r_have_prev  <= 1'b1;
                r_off        <= r_off + rd_sz;
            end
            bth_pkg::OP_ADD_NEXT: begin
                r_sz <= r_sz + rd_sz;
            end
            bth_pkg::OP_ADD_PREV: begin
                r_sz  <= r_sz + (r_off - r_prev);
                r_off <= r_prev;
            end
            default: begin
            end
        endcase

        case (i_cmd.res)
            bth_pkg::RES_ALLOC_OK: begin
                r_result_address <= i_heap_base + 32'({r_off, 3'b100});
                r_status         <= bth_pkg::ST_DONE;
            end
            bth_pkg::RES_FAIL: begin
                r_result_address <= '0;
                r_status         <= bth_pkg::ST_FAIL;
            end
            bth_pkg::RES_IGNORE: begin
                r_result_address <= '0;
                r_status         <= bth_pkg::ST_IGNORED;
            end
            bth_pkg::RES_DONE: begin
                r_result_address <= '0;
                r_status         <= bth_pkg::ST_DONE;
            end
            default: begin
            end
        endcase

        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res != bth_pkg::RES_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_result_address;
    assign o_status         = r_status;

    a_res_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res != bth_pkg::RES_NONE) |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bth_pkg::OP_ADVANCE) |-> rd_ok)
        else $error("walk advanced over a bad header");

    a_rest_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wsel == bth_pkg::WS_REST_HDR) |-> (r_rest >= bth_pkg::OFF_W'(bth_pkg::MIN8)))
        else $error("split remainder below minimum block");

endmodule

// ===== hdl/bth_ctrl.sv =====
module bth_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_mode,
    input  bth_pkg::t_stat i_stat,
    output logic           o_ready,
    output bth_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_INIT_SET,
        S_INIT_HDR,
        S_INIT_FTR,
        S_IDLE,
        S_A_CHECK,
        S_A_RD,
        S_A_EVAL,
        S_A_W0,
        S_A_W1,
        S_A_W2,
        S_A_W3,
        S_A_F0,
        S_A_F1,
        S_F_CHECK,
        S_F_RD,
        S_F_EVAL,
        S_F_NRD,
        S_F_NEVAL,
        S_F_PREV,
        S_F_W0,
        S_F_W1,
        S_FINISH
    } t_state;

    t_state        r_state, n_state;
    bth_pkg::t_res r_res, n_res;
    logic          r_reply, n_reply;

    always_comb begin
        n_state        = r_state;
        n_res          = r_res;
        n_reply        = r_reply;
        o_cmd          = '0;
        o_cmd.op       = bth_pkg::OP_NONE;
        o_cmd.rsel     = bth_pkg::RS_CUR;
        o_cmd.wsel     = bth_pkg::WS_NONE;
        o_cmd.wr_alloc = 1'b0;
        o_cmd.res      = bth_pkg::RES_NONE;
        o_ready        = 1'b0;
        case (r_state)
            S_INIT_SET: begin
                o_cmd.op = bth_pkg::OP_INIT;
                n_state  = S_INIT_HDR;
            end
            S_INIT_HDR: begin
                o_cmd.wsel = bth_pkg::WS_CUR_HDR;
                n_state    = S_INIT_FTR;
            end
            S_INIT_FTR: begin
                o_cmd.wsel = bth_pkg::WS_CUR_FTR;
                n_res      = bth_pkg::RES_DONE;
                n_state    = r_reply ? S_FINISH : S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = bth_pkg::OP_LOAD;
                    case (i_mode)
                        bth_pkg::MODE_ALLOC: n_state = S_A_CHECK;
                        bth_pkg::MODE_FREE:  n_state = S_F_CHECK;
                        bth_pkg::MODE_INIT: begin
                            n_reply = 1'b1;
                            n_state = S_INIT_SET;
                        end
                        default: begin
                            n_res   = bth_pkg::RES_DONE;
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_A_CHECK: begin
                if (i_stat.req_bad) begin
                    n_res   = bth_pkg::RES_FAIL;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                if (i_stat.off_end) begin
                    n_res   = bth_pkg::RES_FAIL;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_A_EVAL;
                end
            end
            S_A_EVAL: begin
                if (!i_stat.rd_ok) begin
                    n_res   = bth_pkg::RES_FAIL;
                    n_state = S_FINISH;
                end else if (i_stat.fit) begin
                    o_cmd.op = bth_pkg::OP_TAKE;
                    n_res    = bth_pkg::RES_ALLOC_OK;
                    n_state  = i_stat.split ? S_A_W0 : S_A_F0;
                end else begin
                    o_cmd.op = bth_pkg::OP_ADVANCE;
                    n_state  = S_A_RD;
                end
            end
            S_A_W0: begin
                o_cmd.wsel = bth_pkg::WS_NEED_HDR;
                n_state    = S_A_W1;
            end
            S_A_W1: begin
                o_cmd.wsel = bth_pkg::WS_NEED_FTR;
                n_state    = S_A_W2;
            end
            S_A_W2: begin
                o_cmd.wsel = bth_pkg::WS_REST_HDR;
                n_state    = S_A_W3;
            end
            S_A_W3: begin
                o_cmd.wsel = bth_pkg::WS_REST_FTR;
                n_state    = S_FINISH;
            end
            S_A_F0: begin
                o_cmd.wsel     = bth_pkg::WS_CUR_HDR;
                o_cmd.wr_alloc = 1'b1;
                n_state        = S_A_F1;
            end
            S_A_F1: begin
                o_cmd.wsel     = bth_pkg::WS_CUR_FTR;
                o_cmd.wr_alloc = 1'b1;
                n_state        = S_FINISH;
            end
            S_F_CHECK: begin
                if (i_stat.data_null) begin
                    n_res   = bth_pkg::RES_IGNORE;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                if (i_stat.off_end) begin
                    n_res   = bth_pkg::RES_IGNORE;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_F_EVAL;
                end
            end
            S_F_EVAL: begin
                if (!i_stat.rd_ok || (!i_stat.hit && i_stat.past)) begin
                    n_res   = bth_pkg::RES_IGNORE;
                    n_state = S_FINISH;
                end else if (i_stat.hit) begin
                    o_cmd.op = bth_pkg::OP_TAKE;
                    if (i_stat.rd_free) begin
                        n_res   = bth_pkg::RES_IGNORE;
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_F_NRD;
                    end
                end else begin
                    o_cmd.op = bth_pkg::OP_ADVANCE;
                    n_state  = S_F_RD;
                end
            end
            S_F_NRD: begin
                o_cmd.rsel = bth_pkg::RS_NEXT;
                n_state    = i_stat.next_end ? S_F_PREV : S_F_NEVAL;
            end
            S_F_NEVAL: begin
                o_cmd.rsel = bth_pkg::RS_NEXT;
                if (i_stat.rd_ok && i_stat.rd_free) begin
                    o_cmd.op = bth_pkg::OP_ADD_NEXT;
                end
                n_state = S_F_PREV;
            end
            S_F_PREV: begin
                if (i_stat.prev_free) begin
                    o_cmd.op = bth_pkg::OP_ADD_PREV;
                end
                n_state = S_F_W0;
            end
            S_F_W0: begin
                o_cmd.wsel = bth_pkg::WS_CUR_HDR;
                n_state    = S_F_W1;
            end
            S_F_W1: begin
                o_cmd.wsel = bth_pkg::WS_CUR_FTR;
                n_res      = bth_pkg::RES_DONE;
                n_state    = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res = r_res;
                    n_reply   = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_SET;
            r_res   <= bth_pkg::RES_NONE;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
            r_reply <= n_reply;
        end
    end

    a_ftr_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wsel == bth_pkg::WS_CUR_FTR) |-> ($past(o_cmd.wsel) == bth_pkg::WS_CUR_HDR))
        else $error("footer write without header write");

    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == bth_pkg::OP_LOAD) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");

    a_no_write_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> ((o_cmd.wsel == bth_pkg::WS_NONE) && (o_cmd.res == bth_pkg::RES_NONE)))
        else $error("tag write or result while taking a request");

endmodule
